>>> hdl/mpm_pkg.sv
package mpm_pkg;

	localparam int SLOTS      = 8;
	localparam int PATH_MAX   = 64;
	localparam int STORE_MAX  = PATH_MAX - 1;
	localparam int OFFSET_MAX = 127;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TGT_W  = $clog2(SLOTS + 1);
	localparam int POS_W  = $clog2(PATH_MAX + 1);
	localparam int LEN_W  = $clog2(PATH_MAX);
	localparam int ADDR_W = $clog2(PATH_MAX);
	localparam int REL_W  = (POS_W + 1 > 8) ? POS_W + 1 : 8;

	localparam logic [7:0] SLASH = 8'h2F;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NO_MATCH = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OPEN_NONE   = 2'd0,
		OPEN_MOUNT  = 2'd1,
		OPEN_LOOKUP = 2'd2
	} open_t;

	// per-character control from the sequencer to the slot table
	typedef struct packed {
		logic              step;
		logic              restart;
		logic              lookup;
		logic              is_slash;
		logic [POS_W-1:0]  pos;
		logic [7:0]        ch;
		logic              commit;
		logic [TGT_W-1:0]  target;
		logic [LEN_W-1:0]  len;
	} ctrl_t;

	// slot table answers
	typedef struct packed {
		logic [TGT_W-1:0]  free_slot;
		logic              found;
		logic [SLOT_W-1:0] best;
		logic [LEN_W-1:0]  win_len;
		logic              best_slash;
	} res_t;

endpackage

>>> hdl/mpm_ram.sv
module mpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/mpm_slot_table.sv
module mpm_slot_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mpm_pkg::ctrl_t                     ctrl,
	input  logic [mpm_pkg::SLOTS-1:0][7:0]     rd_lane,
	input  logic [mpm_pkg::POS_W-1:0]          plen,
	output mpm_pkg::res_t                      res
);

	logic [mpm_pkg::SLOTS-1:0]                     used_q;
	logic [mpm_pkg::SLOTS-1:0]                     alive_q;
	logic [mpm_pkg::SLOTS-1:0]                     slash_q;
	logic [mpm_pkg::SLOTS-1:0][mpm_pkg::LEN_W-1:0] len_q;
	logic [mpm_pkg::SLOTS-1:0]                     alive_n;
	logic [mpm_pkg::SLOTS-1:0]                     slash_n;

	// per-lane prefix tracking for one lookup character
	always_comb begin
		logic [mpm_pkg::POS_W-1:0] len_x;
		for (int i = 0; i < mpm_pkg::SLOTS; i++) begin
			len_x = mpm_pkg::POS_W'(len_q[i]);
			alive_n[i] = ctrl.restart ? 1'b1 : alive_q[i];
			slash_n[i] = ctrl.restart ? 1'b0 : slash_q[i];
			if (ctrl.lookup && used_q[i]) begin
				if (ctrl.pos < len_x) begin
					alive_n[i] = alive_n[i] & (rd_lane[i] == ctrl.ch);
				end else if (ctrl.pos == len_x) begin
					slash_n[i] = ctrl.is_slash;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			alive_q <= '1;
			slash_q <= '0;
			len_q   <= '0;
		end else if (ctrl.step) begin
			alive_q <= alive_n;
			slash_q <= slash_n;
			if (ctrl.commit) begin
				used_q[ctrl.target[mpm_pkg::SLOT_W-1:0]] <= 1'b1;
				len_q[ctrl.target[mpm_pkg::SLOT_W-1:0]]  <= ctrl.len;
			end
		end
	end

	always_comb begin
		logic [mpm_pkg::POS_W-1:0] len_x;
		logic                      cand;
		// lowest free slot, SLOTS when none
		res.free_slot  = mpm_pkg::TGT_W'(mpm_pkg::SLOTS);
		res.found      = 1'b0;
		res.best       = '0;
		res.win_len    = '0;
		res.best_slash = 1'b0;
		for (int i = mpm_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				res.free_slot = mpm_pkg::TGT_W'(i);
			end
		end
		// longest match, lowest slot on ties
		for (int i = 0; i < mpm_pkg::SLOTS; i++) begin
			len_x = mpm_pkg::POS_W'(len_q[i]);
			cand = used_q[i] && alive_q[i] && (len_x <= plen) &&
				(len_q[i] <= mpm_pkg::LEN_W'(1) || len_x == plen || slash_q[i]);
			if (cand && len_q[i] > res.win_len) begin
				res.found      = 1'b1;
				res.best       = mpm_pkg::SLOT_W'(i);
				res.win_len    = len_q[i];
				res.best_slash = slash_q[i];
			end
		end
	end

endmodule

>>> hdl/mount_path_prefix_match.sv
// mount table with longest-prefix lookup. paths stream in one byte per request on s_tdata,
// s_tuser selects mount (0) or lookup (1), s_tlast closes the path and yields exactly one
// result on m_tdata. a mount path lands in the lowest free slot (truncated to PATH_MAX-1
// bytes, status full when no slot is free); a lookup returns the longest stored prefix that
// ends at the path end or before a '/', root matching anywhere, plus the offset of the
// relative path. a zero byte ends path content, a change of s_tuser mid-path drops the open
// path. stored bytes live in one synchronous ram per slot, all read at the current byte
// position. each byte goes through a ram read, then compare and flag update; the closing
// byte of a path then forms the result into the output register. the output register lets
// the next byte in while a result waits; only a new result stalls.
module mount_path_prefix_match (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tuser,   // [0] kind
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [1:0] status, [4:2] slot, [11:5] rel_offset, [15:12] zero
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_EXEC   = 3'b010,
		S_RESULT = 3'b100
	} state_t;

	state_t                       state_q;
	mpm_pkg::open_t               open_q;
	logic [mpm_pkg::POS_W-1:0]    pos_q;
	logic [mpm_pkg::TGT_W-1:0]    target_q;
	logic                         ended_q;
	logic                         first_slash_q;

	// accepted request
	logic                         kind_s1;
	logic [7:0]                   ch_s1;
	logic                         last_s1;
	logic                         restart_s1;

	// output register
	logic                         out_valid_q;
	logic [1:0]                   out_status_q;
	logic [2:0]                   out_slot_q;
	logic [6:0]                   out_rel_q;

	logic                         accept;
	mpm_pkg::open_t               open_kind;
	logic                         restart_in;
	logic [mpm_pkg::ADDR_W-1:0]   raddr;
	logic [mpm_pkg::SLOTS-1:0][7:0] rd_lane;

	logic [mpm_pkg::POS_W-1:0]    pos_e;
	logic [mpm_pkg::TGT_W-1:0]    target_e;
	logic                         ended_e;
	logic                         fs_e;
	logic                         live_char;
	logic                         mount_wr;
	logic                         lookup_en;
	logic                         is_slash;
	logic [mpm_pkg::POS_W-1:0]    pos_n;

	mpm_pkg::ctrl_t               ctrl;
	mpm_pkg::res_t                res;

	logic                         out_free;
	mpm_pkg::status_t             r_status;
	logic [2:0]                   r_slot;
	logic [mpm_pkg::REL_W-1:0]    rel_w;
	logic [6:0]                   r_rel;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign open_kind = s_tuser ? mpm_pkg::OPEN_LOOKUP : mpm_pkg::OPEN_MOUNT;
	assign restart_in = (open_q != open_kind);
	// read address is the byte position this request will compare at
	assign raddr     = restart_in ? '0 : pos_q[mpm_pkg::ADDR_W-1:0];

	// state seen by this byte, after a possible restart of the path
	assign pos_e     = restart_s1 ? '0 : pos_q;
	assign ended_e   = restart_s1 ? 1'b0 : ended_q;
	assign fs_e      = restart_s1 ? 1'b0 : first_slash_q;
	assign target_e  = restart_s1 ? (kind_s1 ? mpm_pkg::TGT_W'(mpm_pkg::SLOTS) : res.free_slot)
	                              : target_q;

	assign is_slash  = (ch_s1 == mpm_pkg::SLASH);
	assign live_char = (state_q == S_EXEC) && !ended_e && (ch_s1 != 8'h00);
	assign mount_wr  = live_char && !kind_s1 && (target_e < mpm_pkg::TGT_W'(mpm_pkg::SLOTS)) &&
	                   (pos_e < mpm_pkg::POS_W'(mpm_pkg::STORE_MAX));
	assign lookup_en = live_char && kind_s1 && (pos_e < mpm_pkg::POS_W'(mpm_pkg::PATH_MAX));
	assign pos_n     = pos_e + mpm_pkg::POS_W'(mount_wr || lookup_en);

	// one byte lane per slot, all read at the same position
	for (genvar g = 0; g < mpm_pkg::SLOTS; g++) begin : g_lane
		mpm_ram #(
			.WIDTH(8),
			.DEPTH(mpm_pkg::PATH_MAX)
		) u_ram (
			.clk   (clk),
			.we    (mount_wr && (target_e == mpm_pkg::TGT_W'(g))),
			.waddr (pos_e[mpm_pkg::ADDR_W-1:0]),
			.wdata (ch_s1),
			.raddr (raddr),
			.rdata (rd_lane[g])
		);
	end

	always_comb begin
		ctrl.step     = (state_q == S_EXEC);
		ctrl.restart  = restart_s1;
		ctrl.lookup   = lookup_en;
		ctrl.is_slash = is_slash;
		ctrl.pos      = pos_e;
		ctrl.ch       = ch_s1;
		// mount closes: record length and mark slot used
		ctrl.commit   = (state_q == S_EXEC) && last_s1 && !kind_s1 &&
		                (target_e < mpm_pkg::TGT_W'(mpm_pkg::SLOTS));
		ctrl.target   = target_e;
		ctrl.len      = pos_n[mpm_pkg::LEN_W-1:0];
	end

	mpm_slot_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.rd_lane (rd_lane),
		.plen    (pos_q),
		.res     (res)
	);

	// result forming, from the state left by the closing byte
	always_comb begin
		rel_w = mpm_pkg::REL_W'(res.win_len) +
		        mpm_pkg::REL_W'((pos_q > mpm_pkg::POS_W'(res.win_len)) && res.best_slash);
		r_rel = (rel_w > mpm_pkg::REL_W'(mpm_pkg::OFFSET_MAX)) ? 7'(mpm_pkg::OFFSET_MAX)
		                                                       : rel_w[6:0];
		r_status = mpm_pkg::ST_OK;
		r_slot   = '0;
		if (!kind_s1) begin
			if (target_q < mpm_pkg::TGT_W'(mpm_pkg::SLOTS)) begin
				r_slot = 3'(target_q);
			end else begin
				r_status = mpm_pkg::ST_FULL;
			end
			r_rel = '0;
		end else if (pos_q == '0 || !first_slash_q || !res.found) begin
			r_status = mpm_pkg::ST_NO_MATCH;
			r_rel    = '0;
		end else begin
			r_slot = 3'(res.best);
		end
	end

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			open_q        <= mpm_pkg::OPEN_NONE;
			pos_q         <= '0;
			target_q      <= '0;
			ended_q       <= 1'b0;
			first_slash_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			// a new result replaces a taken one in the same cycle
			if (state_q == S_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					pos_q         <= pos_n;
					target_q      <= target_e;
					ended_q       <= ended_e || (ch_s1 == 8'h00);
					first_slash_q <= (lookup_en && pos_e == '0) ? is_slash : fs_e;
					if (last_s1) begin
						open_q  <= mpm_pkg::OPEN_NONE;
						state_q <= S_RESULT;
					end else begin
						open_q  <= kind_s1 ? mpm_pkg::OPEN_LOOKUP : mpm_pkg::OPEN_MOUNT;
						state_q <= S_IDLE;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= s_tuser;
			ch_s1      <= s_tdata;
			last_s1    <= s_tlast;
			restart_s1 <= restart_in;
		end
		if (state_q == S_RESULT && out_free) begin
			out_status_q <= r_status;
			out_slot_q   <= r_slot;
			out_rel_q    <= r_rel;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_rel_q, out_slot_q, out_status_q};

endmodule

>>> hdl/mpm_checker.sv
module mpm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a result held back keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an accepted byte keeps the engine busy, so requests are never taken back to back
	a_byte_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken on back-to-back cycles");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("undefined status code");

	// failed requests carry no slot or offset
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tdata[15:2] == 14'd0)
		else $error("failed result carries slot or offset");

endmodule

bind mount_path_prefix_match mpm_checker u_mpm_checker (.*);
